// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/bgcd_pkg.sv -----
// Types, constants and step functions for the binary GCD modular inverse
package bgcd_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int MAX_STEPS    = 128;
    localparam int STEP_LIMIT   = 4096;
    // number of unrolled step stages
    localparam int NUM_STEPS    = (MAX_STEPS > STEP_LIMIT) ? STEP_LIMIT : MAX_STEPS;

    // stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = ((2 * OPERAND_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OPERAND_BITS + 7) / 8) * 8;

    typedef logic [OPERAND_BITS-1:0] t_opnd;

    // working state of one item between step stages
    typedef struct packed {
        t_opnd u;
        t_opnd v;
        t_opnd b;
        t_opnd x1;
        t_opnd x2;
    } t_state;

    // one result word
    typedef struct packed {
        t_opnd inverse;
        logic  no_inverse;
    } t_result;

    // halve modulo b: add b first when odd, then halve the full sum including its carry
    function automatic t_opnd half_mod(input t_opnd x, input t_opnd b);
        logic [OPERAND_BITS:0] s;
        s = {1'b0, x} + {1'b0, b};
        return x[0] ? s[OPERAND_BITS:1] : (x >> 1);
    endfunction

    // subtract modulo b: add b back when x is below y
    function automatic t_opnd sub_mod(input t_opnd x, input t_opnd y, input t_opnd b);
        t_opnd corr;
        corr = (x >= y) ? '0 : b;
        return x - y + corr;
    endfunction

endpackage

// ----- hdl/binary_gcd_modular_inverse.sv -----
// Path: input register, one register stage per GCD iteration, final stage, output
// register. Throughput: one word per cycle while the pipeline is not stalled; each
// step stage does one compare, one subtract and one modular halve or subtract.
// A held output parks one word in the skid slot; from the next cycle tready is low
// and the whole pipeline holds until the slot empties.
// Reset (synchronous, active low) clears only the valid bits; no clearing pass.
`include "assert_macros.svh"

module binary_gcd_modular_inverse
    import bgcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // value, modulus, zero pad
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // inverse, zero pad
    output logic                  o_m_axis_tuser   // no_inverse
);

    logic    w_en;
    logic    r_in_vld;
    t_state  r_in_st;
    t_state  n_in_st;
    logic    w_vld [0:NUM_STEPS];
    t_state  w_st  [0:NUM_STEPS];
    logic    w_fin_vld;
    t_result w_fin_res;
    logic    w_out_vld;
    t_result w_out_res;

    // input register: load the starting state of the iteration
    always_comb begin
        n_in_st.u  = i_s_axis_tdata[OPERAND_BITS-1:0];
        n_in_st.v  = i_s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
        n_in_st.b  = i_s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
        n_in_st.x1 = t_opnd'(1);
        n_in_st.x2 = '0;
    end

    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_in_st <= n_in_st;
        end
    end

    assign w_vld[0] = r_in_vld;
    assign w_st[0]  = r_in_st;

    // unrolled iteration stages
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        bgcd_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[k]),
            .i_st    (w_st[k]),
            .o_vld   (w_vld[k+1]),
            .o_st    (w_st[k+1])
        );
    end

    // result selection and reduction
    bgcd_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[NUM_STEPS]),
        .i_st    (w_st[NUM_STEPS]),
        .o_vld   (w_fin_vld),
        .o_res   (w_fin_res)
    );

    // output register and skid slot; its ready is the pipeline enable
    bgcd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fin_vld),
        .i_res   (w_fin_res),
        .o_ready (w_en),
        .o_vld   (w_out_vld),
        .o_res   (w_out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tvalid = w_out_vld;
    assign o_m_axis_tdata  = OUT_DATA_W'(w_out_res.inverse);
    assign o_m_axis_tuser  = w_out_res.no_inverse;

    // checks
    `ASSERT_CLK(a_fail_zero, (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0), "failed inverse carries nonzero data")
    `ASSERT_CLK(a_stall_holds, (!w_en) |=> $stable(w_fin_vld), "final stage moved during stall")
    `ASSERT_CLK(a_skid_out, (!w_en) |-> o_m_axis_tvalid, "skid slot full with output empty")

endmodule

// ----- hdl/bgcd_step.sv -----
// One registered iteration of the binary extended GCD
module bgcd_step
    import bgcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_state i_st,
    output logic   o_vld,
    output t_state o_st
);

    logic   r_vld;
    t_state r_st;
    t_state n_st;
    logic   w_fin;

    // stop once either side has reached one
    assign w_fin = (i_st.u == t_opnd'(1)) || (i_st.v == t_opnd'(1));

    // next state: halve u if even, else v if even, else subtract the smaller from the larger
    always_comb begin
        n_st = i_st;
        if (!w_fin) begin
            priority if (!i_st.u[0]) begin
                n_st.u  = i_st.u >> 1;
                n_st.x1 = half_mod(i_st.x1, i_st.b);
            end else if (!i_st.v[0]) begin
                n_st.v  = i_st.v >> 1;
                n_st.x2 = half_mod(i_st.x2, i_st.b);
            end else if (i_st.u >= i_st.v) begin
                n_st.u  = i_st.u - i_st.v;
                n_st.x1 = sub_mod(i_st.x1, i_st.x2, i_st.b);
            end else begin
                n_st.v  = i_st.v - i_st.u;
                n_st.x2 = sub_mod(i_st.x2, i_st.x1, i_st.b);
            end
        end
    end

    // stage register, advances with the pipeline enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ----- hdl/bgcd_final.sv -----
// Result selection, final reduction below the modulus and failure flag
module bgcd_final
    import bgcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_state  i_st,
    output logic    o_vld,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;
    t_result n_res;
    t_opnd   w_sel;
    t_opnd   w_red;
    logic    w_u_one;
    logic    w_v_one;

    assign w_u_one = (i_st.u == t_opnd'(1));
    assign w_v_one = (i_st.v == t_opnd'(1));
    assign w_sel   = w_u_one ? i_st.x1 : i_st.x2;
    assign w_red   = (w_sel >= i_st.b) ? (w_sel - i_st.b) : w_sel;

    // no inverse: field forced to zero
    always_comb begin
        n_res.no_inverse = !w_u_one && !w_v_one;
        n_res.inverse    = n_res.no_inverse ? '0 : w_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

// ----- hdl/bgcd_skid.sv -----
// Output register with a skid slot so the pipeline stall is registered
module bgcd_skid
    import bgcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_vld,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_out_vld;
    t_result r_out;
    logic    r_skid_vld;
    t_result r_skid;

    // space while the skid slot is empty
    assign o_ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            // output slot free: refill from skid first, else from input
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_vld;
                r_out     <= i_res;
            end
        end else if (i_vld && !r_skid_vld) begin
            // output held: park the incoming word
            r_skid     <= i_res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_out;

endmodule
